### rtl/bounded_sequence_list_engine_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bounded sequence list engine.
// Concurrent assertions clocked on a rising edge with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_SEQUENCE_LIST_ENGINE_CORE_ASSERT_SVH
`define BOUNDED_SEQUENCE_LIST_ENGINE_CORE_ASSERT_SVH

// General property check.
`define BSLE_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bsle assertion failed");

// Same-cycle implication check.
`define BSLE_ASSERT_IMPLIES(label, clk, rst_n, cond, conseq) \
  `BSLE_ASSERT(label, clk, rst_n, ((cond) |-> (conseq)))

`endif

### rtl/bsle_pkg.sv
// ----------------------------------------------------------------------------
// bsle_pkg
// Shared types and constants of the bounded sequence list engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bsle_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int VALUE_W       = 32;
  localparam int POS_W         = 5;
  localparam int CNT_OUT_W     = 5;

  typedef enum logic [2:0] {
    OP_PUSH_TAIL  = 3'd0,
    OP_POP_TAIL   = 3'd1,
    OP_PUSH_FRONT = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_INSERT_AT  = 3'd4,
    OP_ERASE_AT   = 3'd5,
    OP_READ_SIZE  = 3'd6,
    OP_CLEAR      = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BEYOND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CM_HOLD   = 2'd0,
    CM_INSERT = 2'd1,
    CM_ERASE  = 2'd2
  } cell_mode_e;

  typedef enum logic {
    S_IDLE    = 1'b0,
    S_EXTRACT = 1'b1
  } state_e;

  typedef struct packed {
    cell_mode_e mode;
    logic       tap_load;
    logic       tap_shift;
  } cell_ctrl_t;

endpackage

`default_nettype wire

### rtl/bsle_cell.sv
// ----------------------------------------------------------------------------
// bsle_cell
// One storage cell of the chain: holds one element and one extraction tap.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bsle_cell #(
  parameter int IDX_W = 5,
  parameter int INDEX = 0
) (
  input  logic                                clk_i,
  input  bsle_pkg::cell_ctrl_t                ctrl_i,
  input  logic [IDX_W-1:0]                    idx_i,
  input  logic signed [bsle_pkg::VALUE_W-1:0] ins_value_i,
  input  logic signed [bsle_pkg::VALUE_W-1:0] left_value_i,
  input  logic signed [bsle_pkg::VALUE_W-1:0] right_value_i,
  input  logic signed [bsle_pkg::VALUE_W-1:0] right_tap_i,
  output logic signed [bsle_pkg::VALUE_W-1:0] value_o,
  output logic signed [bsle_pkg::VALUE_W-1:0] tap_o
);
  import bsle_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic signed [VALUE_W-1:0] value_q, value_d;
  logic signed [VALUE_W-1:0] tap_q, tap_d;

  always_comb begin
    value_d = value_q;
    case (ctrl_i.mode)
      CM_INSERT: begin
        if (MY_IDX == idx_i) begin
          value_d = ins_value_i;
        end else if (MY_IDX > idx_i) begin
          value_d = left_value_i;
        end
      end
      CM_ERASE: begin
        if (MY_IDX >= idx_i) begin
          value_d = right_value_i;
        end
      end
      default: begin
        value_d = value_q;
      end
    endcase
  end

  always_comb begin
    tap_d = tap_q;
    if (ctrl_i.tap_load) begin
      tap_d = value_q;
    end else if (ctrl_i.tap_shift) begin
      tap_d = right_tap_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    tap_q   <= tap_d;
  end

  assign value_o = value_q;
  assign tap_o   = tap_q;

endmodule

`default_nettype wire

### rtl/bsle_ctrl.sv
// ----------------------------------------------------------------------------
// bsle_ctrl
// Request decoder, element counter, extraction sequencer and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bsle_ctrl #(
  parameter int DEPTH = bsle_pkg::DEPTH_DEFAULT,
  parameter int IDX_W = 5
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  bsle_pkg::op_e                         op_i,
  input  logic [bsle_pkg::POS_W-1:0]            position_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [bsle_pkg::VALUE_W-1:0]   popped_value_o,
  output logic [bsle_pkg::CNT_OUT_W-1:0]        element_count_o,
  output bsle_pkg::status_e                     status_o,
  input  logic signed [bsle_pkg::VALUE_W-1:0]   tap_head_i,
  output bsle_pkg::cell_ctrl_t                  cell_ctrl_o,
  output logic [IDX_W-1:0]                      idx_o
);
  import bsle_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  state_e                    state_q, state_d;
  logic [CNT_W-1:0]          count_q, count_d;
  logic [IDX_W-1:0]          shift_cnt_q, shift_cnt_d;
  logic                      out_valid_q, out_valid_d;
  logic signed [VALUE_W-1:0] popped_q, popped_d;
  logic [CNT_OUT_W-1:0]      out_count_q, out_count_d;
  status_e                   status_q, status_d;

  logic                      accept;
  logic                      full;
  logic                      empty;
  logic [POS_W-1:0]          pos_idx;
  logic [IDX_W-1:0]          req_idx;
  logic [IDX_W-1:0]          cnt_ext;
  logic [IDX_W-1:0]          eff_idx;
  cell_mode_e                mode;
  logic                      pop;
  status_e                   status;
  logic                      extract_done;

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (count_q == CNT_W'(DEPTH));
  assign empty      = (count_q == '0);
  assign pos_idx    = (position_i <= POS_W'(1)) ? '0 : position_i - POS_W'(1);
  assign req_idx    = IDX_W'(pos_idx);
  assign cnt_ext    = IDX_W'(count_q);

  always_comb begin
    mode    = CM_HOLD;
    eff_idx = '0;
    pop     = 1'b0;
    status  = ST_OK;
    unique case (op_i) inside
      OP_PUSH_TAIL, OP_PUSH_FRONT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          mode    = CM_INSERT;
          eff_idx = (op_i == OP_PUSH_TAIL) ? cnt_ext : '0;
        end
      end
      OP_POP_TAIL, OP_POP_FRONT: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          mode    = CM_ERASE;
          pop     = 1'b1;
          eff_idx = (op_i == OP_POP_TAIL) ? cnt_ext - IDX_W'(1) : '0;
        end
      end
      OP_INSERT_AT: begin
        if (full) begin
          status = ST_FULL;
        end else if (req_idx > cnt_ext) begin
          status = ST_BEYOND;
        end else begin
          mode    = CM_INSERT;
          eff_idx = req_idx;
        end
      end
      OP_ERASE_AT: begin
        if (req_idx > cnt_ext) begin
          status = ST_BEYOND;
        end else if (req_idx == cnt_ext) begin
          status = empty ? ST_EMPTY : ST_OK;
        end else begin
          mode    = CM_ERASE;
          pop     = 1'b1;
          eff_idx = req_idx;
        end
      end
      OP_READ_SIZE: begin
        status = ST_OK;
      end
      OP_CLEAR: begin
        status = ST_OK;
      end
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (accept) begin
      if (op_i == OP_CLEAR) begin
        count_d = '0;
      end else if (mode == CM_INSERT) begin
        count_d = count_q + CNT_W'(1);
      end else if (mode == CM_ERASE) begin
        count_d = count_q - CNT_W'(1);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && pop) begin
          state_d = S_EXTRACT;
        end
      end
      S_EXTRACT: begin
        if (shift_cnt_q == '0) begin
          state_d = S_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    extract_done          = (state_q == S_EXTRACT) && (shift_cnt_q == '0);
    cell_ctrl_o.mode      = accept ? mode : CM_HOLD;
    cell_ctrl_o.tap_load  = accept && pop;
    cell_ctrl_o.tap_shift = (state_q == S_EXTRACT) && (shift_cnt_q != '0);
    idx_o                 = eff_idx;

    shift_cnt_d = shift_cnt_q;
    if (accept && pop) begin
      shift_cnt_d = eff_idx;
    end else if (cell_ctrl_o.tap_shift) begin
      shift_cnt_d = shift_cnt_q - IDX_W'(1);
    end

    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if ((accept && !pop) || extract_done) begin
      out_valid_d = 1'b1;
    end

    popped_d    = popped_q;
    out_count_d = out_count_q;
    status_d    = status_q;
    if (accept) begin
      popped_d    = '0;
      out_count_d = CNT_OUT_W'(count_d);
      status_d    = status;
    end else if (extract_done) begin
      popped_d = tap_head_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      shift_cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      shift_cnt_q <= shift_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    popped_q    <= popped_d;
    out_count_q <= out_count_d;
    status_q    <= status_d;
  end

  assign out_valid_o     = out_valid_q;
  assign popped_value_o  = popped_q;
  assign element_count_o = out_count_q;
  assign status_o        = status_q;

endmodule

`default_nettype wire

### rtl/bounded_sequence_list_engine_core.sv
// ----------------------------------------------------------------------------
// bounded_sequence_list_engine_core
// Ordered list of up to DEPTH signed 32-bit elements held in a chain of cells.
// ----------------------------------------------------------------------------
// Requests enter on the input channel (op, position, value) and every request
// returns one result (popped value, element count, status) on the output
// channel. Both channels use valid/ready.
// Element 1 sits in cell 0. Inserts and erases are done in the cycle the
// request is taken: every cell compares its own index with the target index
// and loads from its left or right neighbor at once.
// A request that removes nothing has its result in the cycle after acceptance,
// and such requests can be taken every cycle unless a result is held back.
// A request that removes element p (pop or erase) copies the row into the
// cells' extraction taps and shifts them toward cell 0 until element p
// reaches the tap of cell 0, from which its result is registered; no request
// is taken meanwhile, and the wait through the tap chain grows with p.
// While a result waits for the receiver, ready stays low; the result register
// holds its contents until taken.
// Reset empties the list at once; cell contents are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bounded_sequence_list_engine_core #(
  parameter int DEPTH = bsle_pkg::DEPTH_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  bsle_pkg::op_e                       op_i,
  input  logic [bsle_pkg::POS_W-1:0]          position_i,
  input  logic signed [bsle_pkg::VALUE_W-1:0] value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [bsle_pkg::VALUE_W-1:0] popped_value_o,
  output logic [bsle_pkg::CNT_OUT_W-1:0]      element_count_o,
  output bsle_pkg::status_e                   status_o
);
  import bsle_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  cell_ctrl_t                cell_ctrl;
  logic [IDX_W-1:0]          idx;
  logic signed [VALUE_W-1:0] cell_value [DEPTH];
  logic signed [VALUE_W-1:0] cell_tap   [DEPTH];

  bsle_ctrl #(
    .DEPTH(DEPTH),
    .IDX_W(IDX_W)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .position_i     (position_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .popped_value_o (popped_value_o),
    .element_count_o(element_count_o),
    .status_o       (status_o),
    .tap_head_i     (cell_tap[0]),
    .cell_ctrl_o    (cell_ctrl),
    .idx_o          (idx)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VALUE_W-1:0] left_value;
    logic signed [VALUE_W-1:0] right_value;
    logic signed [VALUE_W-1:0] right_tap;

    if (i == 0) begin : g_first
      assign left_value = value_i;
    end else begin : g_inner_left
      assign left_value = cell_value[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_value = '0;
      assign right_tap   = '0;
    end else begin : g_inner_right
      assign right_value = cell_value[i+1];
      assign right_tap   = cell_tap[i+1];
    end

    bsle_cell #(
      .IDX_W(IDX_W),
      .INDEX(i)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (cell_ctrl),
      .idx_i        (idx),
      .ins_value_i  (value_i),
      .left_value_i (left_value),
      .right_value_i(right_value),
      .right_tap_i  (right_tap),
      .value_o      (cell_value[i]),
      .tap_o        (cell_tap[i])
    );
  end

endmodule

`default_nettype wire

### rtl/bsle_checker.sv
// ----------------------------------------------------------------------------
// bsle_checker
// Port-level checks of the bounded sequence list engine, bound to the core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "bounded_sequence_list_engine_core_assert.svh"

module bsle_checker #(
  parameter int DEPTH = bsle_pkg::DEPTH_DEFAULT
) (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_ready_i,
  input logic                                out_valid_i,
  input logic                                out_ready_i,
  input logic signed [bsle_pkg::VALUE_W-1:0] popped_value_i,
  input logic [bsle_pkg::CNT_OUT_W-1:0]      element_count_i,
  input bsle_pkg::status_e                   status_i
);
  import bsle_pkg::*;

  localparam logic [CNT_OUT_W-1:0] FULL_COUNT = CNT_OUT_W'(DEPTH);

  logic stalled;
  logic full_seen;
  logic full_ok;
  logic empty_seen;
  logic empty_ok;

  assign stalled    = out_valid_i && !out_ready_i;
  assign full_seen  = out_valid_i && (status_i == ST_FULL);
  assign full_ok    = (popped_value_i == '0) && (element_count_i == FULL_COUNT);
  assign empty_seen = out_valid_i && (status_i == ST_EMPTY);
  assign empty_ok   = (popped_value_i == '0) && (element_count_i == '0);

  `BSLE_ASSERT(a_popped_holds, clk_i, rst_ni, stalled |=> out_valid_i && $stable(popped_value_i))
  `BSLE_ASSERT(a_fields_hold, clk_i, rst_ni, stalled |=> $stable({element_count_i, status_i}))
  `BSLE_ASSERT_IMPLIES(a_no_take_when_blocked, clk_i, rst_ni, stalled, !in_ready_i)
  `BSLE_ASSERT_IMPLIES(a_full_result, clk_i, rst_ni, full_seen, full_ok)
  `BSLE_ASSERT_IMPLIES(a_empty_result, clk_i, rst_ni, empty_seen, empty_ok)

endmodule

bind bounded_sequence_list_engine_core bsle_checker #(
  .DEPTH(DEPTH)
) u_bsle_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_i     (in_ready_o),
  .out_valid_i    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .popped_value_i (popped_value_o),
  .element_count_i(element_count_o),
  .status_i       (status_o)
);

`default_nettype wire

### sim/tb_bounded_sequence_list_engine_core.sv
// ----------------------------------------------------------------------------
// tb_bounded_sequence_list_engine_core
// Self-checking bench for the bounded sequence list engine.
// ----------------------------------------------------------------------------
// A driver feeds requests from a pending queue onto the input channel, and a
// monitor predicts each accepted request with a queue-based list model and
// compares every result field by field with the oldest prediction. A short
// directed run covers the empty, full and position edge cases; random runs
// then follow under several sender and receiver idle patterns, including a
// long receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_bounded_sequence_list_engine_core;
  import bsle_pkg::*;

  localparam int DEPTH       = DEPTH_DEFAULT;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int RAND_ITEMS  = 190;

  typedef struct {
    op_e                  op;
    logic [POS_W-1:0]     pos;
    logic signed [31:0]   val;
  } request_t;

  typedef struct {
    logic signed [31:0]   popped;
    logic [CNT_OUT_W-1:0] count;
    status_e              status;
  } outcome_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  op_e                  op_i = OP_READ_SIZE;
  logic [POS_W-1:0]     position_i = '0;
  logic signed [31:0]   value_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic signed [31:0]   popped_value_o;
  logic [CNT_OUT_W-1:0] element_count_o;
  status_e              status_o;

  request_t           pending_requests[$];
  outcome_t           expected_outcomes[$];
  logic signed [31:0] list_contents[$];
  int                 gen_count = 0;
  int                 send_idle_pct = 0;
  int                 recv_stall_pct = 0;
  int                 hold_left = 0;
  bit                 hold_request = 1'b0;
  bit                 req_taken = 1'b0;
  int                 err_cnt = 0;
  int                 cycle_cnt = 0;

  bounded_sequence_list_engine_core #(
    .DEPTH(DEPTH)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .position_i     (position_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .popped_value_o (popped_value_o),
    .element_count_o(element_count_o),
    .status_o       (status_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int slot_of(input logic [POS_W-1:0] pos);
    return (pos <= 1) ? 0 : int'(pos) - 1;
  endfunction

  function automatic outcome_t apply_list_request(input request_t req);
    outcome_t res;
    int       idx;
    idx = slot_of(req.pos);
    res.popped = '0;
    res.status = ST_OK;
    case (req.op) inside
      OP_PUSH_TAIL, OP_PUSH_FRONT: begin
        if (list_contents.size() >= DEPTH) res.status = ST_FULL;
        else if (req.op == OP_PUSH_TAIL) list_contents.insert(list_contents.size(), req.val);
        else list_contents.push_front(req.val);
      end
      OP_POP_TAIL: begin
        if (list_contents.size() == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.popped = list_contents[$];
          list_contents.delete(list_contents.size() - 1);
        end
      end
      OP_POP_FRONT: begin
        if (list_contents.size() == 0) res.status = ST_EMPTY;
        else res.popped = list_contents.pop_front();
      end
      OP_INSERT_AT: begin
        if (list_contents.size() >= DEPTH) res.status = ST_FULL;
        else if (idx > list_contents.size()) res.status = ST_BEYOND;
        else list_contents.insert(idx, req.val);
      end
      OP_ERASE_AT: begin
        if (idx > list_contents.size()) begin
          res.status = ST_BEYOND;
        end else if (idx == list_contents.size()) begin
          res.status = (list_contents.size() == 0) ? ST_EMPTY : ST_OK;
        end else begin
          res.popped = list_contents[idx];
          list_contents.delete(idx);
        end
      end
      OP_READ_SIZE: ;
      default: list_contents.delete();
    endcase
    res.count = CNT_OUT_W'(list_contents.size());
    return res;
  endfunction

  function automatic int count_after(input request_t req, input int cnt);
    int idx;
    idx = slot_of(req.pos);
    case (req.op) inside
      OP_PUSH_TAIL, OP_PUSH_FRONT: return (cnt < DEPTH) ? cnt + 1 : cnt;
      OP_POP_TAIL, OP_POP_FRONT:   return (cnt > 0) ? cnt - 1 : cnt;
      OP_INSERT_AT:                return (cnt < DEPTH && idx <= cnt) ? cnt + 1 : cnt;
      OP_ERASE_AT:                 return (idx < cnt) ? cnt - 1 : cnt;
      OP_CLEAR:                    return 0;
      default:                     return cnt;
    endcase
  endfunction

  task automatic queue_request(input op_e op, input int pos, input logic [31:0] val);
    request_t req;
    req.op  = op;
    req.pos = pos[POS_W-1:0];
    req.val = val;
    gen_count = count_after(req, gen_count);
    pending_requests.insert(pending_requests.size(), req);
  endtask

  function automatic logic [31:0] pick_value();
    logic [31:0] corners[4];
    corners = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff};
    if ($urandom_range(99) < 20) return corners[$urandom_range(3)];
    return $urandom;
  endfunction

  task automatic queue_random_requests(input int n);
    op_e grow_ops[3];
    op_e shrink_ops[4];
    op_e op;
    int  grow_pct;
    int  r;
    int  pos;
    grow_ops   = '{OP_PUSH_TAIL, OP_PUSH_FRONT, OP_INSERT_AT};
    shrink_ops = '{OP_POP_TAIL, OP_POP_FRONT, OP_ERASE_AT, OP_ERASE_AT};
    for (int i = 0; i < n; i++) begin
      grow_pct = (gen_count < 12) ? 55 : 40;
      r = $urandom_range(99);
      if (r < grow_pct) op = grow_ops[$urandom_range(2)];
      else if (r < 94) op = shrink_ops[$urandom_range(3)];
      else if (r < 97) op = OP_READ_SIZE;
      else op = OP_CLEAR;
      if ((op == OP_INSERT_AT || op == OP_ERASE_AT) && $urandom_range(99) < 85)
        pos = $urandom_range((gen_count + 1 > DEPTH) ? DEPTH : gen_count + 1);
      else
        pos = $urandom_range(DEPTH);
      queue_request(op, pos, pick_value());
    end
  endtask

  task automatic queue_directed_requests();
    queue_request(OP_POP_TAIL, 0, 32'h0);
    queue_request(OP_POP_FRONT, 16, 32'hffff_ffff);
    queue_request(OP_ERASE_AT, 0, 32'h0);
    queue_request(OP_ERASE_AT, 2, 32'h0);
    queue_request(OP_INSERT_AT, 2, 32'h1234_5678);
    queue_request(OP_INSERT_AT, 0, 32'h8000_0000);
    queue_request(OP_PUSH_TAIL, 31 & 5'h1f, 32'h7fff_ffff);
    queue_request(OP_PUSH_FRONT, 0, 32'hffff_ffff);
    queue_request(OP_INSERT_AT, 4, 32'h0);
    queue_request(OP_INSERT_AT, 1, 32'h5a5a_a5a5);
    queue_request(OP_ERASE_AT, 6, 32'h0);
    queue_request(OP_ERASE_AT, 7, 32'h0);
    for (int i = 0; i < 11; i++) queue_request(OP_PUSH_TAIL, 0, $urandom);
    queue_request(OP_PUSH_TAIL, 0, 32'h1111_1111);
    queue_request(OP_INSERT_AT, 16, 32'h2222_2222);
    queue_request(OP_ERASE_AT, 16, 32'h0);
    queue_request(OP_READ_SIZE, 0, 32'h0);
    queue_request(OP_CLEAR, 0, 32'h0);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    err_cnt++;
  endtask

  task automatic wait_drained();
    while (pending_requests.size() != 0 || in_valid_i || expected_outcomes.size() != 0)
      @(posedge clk_i);
  endtask

  // Monitor: results are checked before the request accepted at the same edge
  // is predicted, since a result always trails its request.
  always @(posedge clk_i) begin
    outcome_t want;
    request_t req;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_outcomes.size() == 0) begin
          report_mismatch("unexpected result", popped_value_o, 32'h0);
        end else begin
          want = expected_outcomes.pop_front();
          if (popped_value_o !== want.popped)
            report_mismatch("popped_value", popped_value_o, want.popped);
          if (element_count_o !== want.count)
            report_mismatch("element_count", 32'(element_count_o), 32'(want.count));
          if (status_o !== want.status)
            report_mismatch("status", 32'(status_o), 32'(want.status));
        end
      end
      if (in_valid_i && in_ready_o) begin
        req.op  = op_i;
        req.pos = position_i;
        req.val = value_i;
        expected_outcomes.insert(expected_outcomes.size(), apply_list_request(req));
        req_taken = 1'b1;
      end
    end
  end

  always @(negedge clk_i) begin
    request_t req;
    logic     next_valid;
    next_valid = in_valid_i && !req_taken;
    req_taken = 1'b0;
    if (rst_ni && !next_valid && pending_requests.size() != 0 &&
        $urandom_range(99) >= send_idle_pct) begin
      req = pending_requests.pop_front();
      op_i       <= req.op;
      position_i <= req.pos;
      value_i    <= req.val;
      next_valid = 1'b1;
    end
    in_valid_i <= next_valid;
  end

  always @(negedge clk_i) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    queue_directed_requests();
    queue_random_requests(RAND_ITEMS);
    wait_drained();

    send_idle_pct = 75;
    queue_random_requests(RAND_ITEMS);
    wait_drained();

    send_idle_pct  = 0;
    recv_stall_pct = 75;
    queue_random_requests(RAND_ITEMS);
    wait_drained();

    send_idle_pct  = 26;
    recv_stall_pct = 26;
    queue_random_requests(RAND_ITEMS);
    wait_drained();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 1'b1;
    queue_random_requests(RAND_ITEMS);
    wait_drained();

    repeat (40) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### bounded_sequence_list_engine_core.f
+incdir+rtl
rtl/bsle_pkg.sv
rtl/bsle_cell.sv
rtl/bsle_ctrl.sv
rtl/bounded_sequence_list_engine_core.sv
rtl/bsle_checker.sv
sim/tb_bounded_sequence_list_engine_core.sv
